@@ src/s2c_pkg.sv @@
// shared types, constants and tables for the spherical to cartesian point converter
package s2c_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RADIUS    = 2'd0,
    REG_MAX_RADIUS    = 2'd1,
    REG_SHIFT_FACTOR  = 2'd2,
    REG_VOLUME_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [17:0] MIN_RADIUS_RST    = 18'd55760;
  localparam logic [17:0] MAX_RADIUS_RST    = 18'd101936;
  localparam logic [15:0] SHIFT_FACTOR_RST  = 16'd64000;
  localparam logic [10:0] VOLUME_HEIGHT_RST = 11'd201;

  // divider: 48 bit dividend, 27 bit divisor, one quotient bit per stage
  localparam int DIV_W = 48;
  localparam int DVS_W = 27;
  // total latency in cycles
  localparam int LAT = DIV_W + 9;

  // cordic datapath widths
  localparam int CW = 34;
  localparam int ZW = 29;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // angles in degrees with eight fraction bits
  localparam logic signed [19:0] HALF_Q8    = 20'sd46080;
  localparam logic signed [19:0] FULL_Q8    = 20'sd92160;
  localparam logic signed [19:0] QUARTER_Q8 = 20'sd23040;

  localparam int OUT_W = 24;

  typedef struct packed {
    logic              neg;
    logic signed [15:0] ang;
  } ang_t;

  typedef struct packed {
    logic signed [CW-1:0] cp;
    logic signed [CW-1:0] sp;
    logic signed [CW-1:0] ct;
    logic signed [CW-1:0] st;
  } trig_t;

  // atan(2^-i) in degrees, 20 fraction bits
  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 29'sd47185920;
      5'd1:  v = 29'sd27855475;
      5'd2:  v = 29'sd14718068;
      5'd3:  v = 29'sd7471121;
      5'd4:  v = 29'sd3750058;
      5'd5:  v = 29'sd1876857;
      5'd6:  v = 29'sd938658;
      5'd7:  v = 29'sd469357;
      5'd8:  v = 29'sd234682;
      5'd9:  v = 29'sd117342;
      5'd10: v = 29'sd58671;
      5'd11: v = 29'sd29335;
      5'd12: v = 29'sd14668;
      5'd13: v = 29'sd7334;
      5'd14: v = 29'sd3667;
      5'd15: v = 29'sd1833;
      5'd16: v = 29'sd917;
      5'd17: v = 29'sd458;
      5'd18: v = 29'sd229;
      5'd19: v = 29'sd115;
      5'd20: v = 29'sd57;
      5'd21: v = 29'sd29;
      5'd22: v = 29'sd14;
      5'd23: v = 29'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/s2c_if.sv @@
// valid/ready channel interfaces for points in and cartesian results out
interface s2c_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] lon_deg;
  logic        [17:0] radial_index;
  logic signed [16:0] colat_deg;

  modport source (output valid, output lon_deg, output radial_index, output colat_deg,
                  input ready);
  modport sink   (input valid, input lon_deg, input radial_index, input colat_deg,
                  output ready);
endinterface

interface s2c_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic signed [23:0] out_z;
  logic               fault;

  modport source (output valid, output out_x, output out_y, output out_z, output fault,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input fault,
                  output ready);
endinterface

@@ src/s2c_cordic.sv @@
// pipelined rotation-mode cordic, one stage per register
module s2c_cordic import s2c_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [CW-1:0] cos_out,
  output logic signed [CW-1:0] sin_out
);

  logic signed [CW-1:0] xs [STAGES+1];
  logic signed [CW-1:0] ys [STAGES+1];
  logic signed [ZW-1:0] zs [STAGES+1];

  assign xs[0] = CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = z_in;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign at = atan_q20(5'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - at;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + at;
        end
      end
    end
  end

  assign cos_out = xs[STAGES];
  assign sin_out = ys[STAGES];

endmodule

@@ src/s2c_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module s2c_div import s2c_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0] work [DIV_W+1];
  logic [DVS_W-1:0] rem  [DIV_W+1];
  logic [DVS_W-1:0] dvs  [DIV_W+1];

  assign work[0] = dividend;
  assign rem[0]  = '0;
  assign dvs[0]  = divisor;

  for (genvar j = 0; j < DIV_W; j++) begin : g_stage
    logic [DVS_W:0] trial;
    logic           ge;
    logic [DVS_W:0] diff;

    // quotient bits shift in at the bottom as dividend bits leave the top
    assign trial = {rem[j], work[j][DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs[j]};
    assign diff  = trial - {1'b0, dvs[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        work[j+1] <= {work[j][DIV_W-2:0], ge};
        dvs[j+1]  <= dvs[j];
      end
    end
  end

  assign quotient = work[DIV_W];

endmodule

@@ src/spherical_to_cartesian_point.sv @@
// top level: spherical point to cartesian x, y, z with saturation and fault flag
//
//   port    dir  handshake     contents
//   pt_in   in   valid/ready   lon_deg, radial_index, colat_deg
//   pt_out  out  valid/ready   out_x, out_y, out_z, fault
//   cfg_*   in   write enable  min_radius, max_radius, shift_factor, volume_height
//
// one point per cycle unless a result is stalled at the output
// latency is set by the 48 stage radius divider; the cordics run beside it
// reset clears the valid bits and loads the register defaults
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
module spherical_to_cartesian_point import s2c_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  s2c_in_if.sink                pt_in,
  s2c_out_if.source             pt_out
);

  localparam int DLY = DIV_W + 2 - CORDIC_STAGES;

  // configuration
  logic [17:0] min_radius;
  logic [17:0] max_radius;
  logic [15:0] shift_factor;
  logic [10:0] volume_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_radius    <= MIN_RADIUS_RST;
      max_radius    <= MAX_RADIUS_RST;
      shift_factor  <= SHIFT_FACTOR_RST;
      volume_height <= VOLUME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_RADIUS:    min_radius    <= cfg_data;
        REG_MAX_RADIUS:    max_radius    <= cfg_data;
        REG_SHIFT_FACTOR:  shift_factor  <= cfg_data[15:0];
        REG_VOLUME_HEIGHT: volume_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // wrap into [-180, 180), then fold into [-90, 90] with a sign flag
  function automatic ang_t fold(input logic signed [19:0] t);
    logic signed [19:0] m;
    logic signed [19:0] a;
    ang_t r;
    if (t < 0)
      m = t + FULL_Q8;
    else if (t >= 2 * FULL_Q8)
      m = t - FULL_Q8 - FULL_Q8;
    else if (t >= FULL_Q8)
      m = t - FULL_Q8;
    else
      m = t;
    a = m - HALF_Q8;
    r.neg = 1'b0;
    if (a > QUARTER_Q8) begin
      a = a - HALF_Q8;
      r.neg = 1'b1;
    end else if (a < -QUARTER_Q8) begin
      a = a + HALF_Q8;
      r.neg = 1'b1;
    end
    r.ang = a[15:0];
    return r;
  endfunction

  function automatic logic [OUT_W:0] sat_out(input logic neg, input logic [44:0] m);
    logic [44:0] nm;
    logic [OUT_W:0] r;
    nm = -m;
    if (neg) begin
      if (m > 45'd8388608) r = {1'b1, 24'h800000};
      else                 r = {1'b0, nm[OUT_W-1:0]};
    end else begin
      if (m > 45'd8388607) r = {1'b1, 24'h7FFFFF};
      else                 r = {1'b0, m[OUT_W-1:0]};
    end
    return r;
  endfunction

  logic [LAT:1] vld;
  logic         en;

  assign en          = !vld[LAT] || pt_out.ready;
  assign pt_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], pt_in.valid};
    end
  end

  // stage 1: angle folding, radius products and the divisor product
  ang_t                    ang_lon;
  ang_t                    ang_col;
  logic [28:0]             mh1;
  logic signed [37:0]      pd1;
  logic [DVS_W-1:0]        d1;
  logic                    zf1;
  logic signed [18:0]      diff_r;
  logic signed [19:0]      t_lon;
  logic signed [19:0]      t_col;

  assign diff_r = $signed({1'b0, max_radius}) - $signed({1'b0, min_radius});
  assign t_lon  = $signed({{2{pt_in.lon_deg[17]}}, pt_in.lon_deg}) + FULL_Q8;
  assign t_col  = $signed({{3{pt_in.colat_deg[16]}}, pt_in.colat_deg}) + HALF_Q8;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_lon <= fold(t_lon);
      ang_col <= fold(t_col);
      mh1     <= min_radius * volume_height;
      pd1     <= $signed({1'b0, pt_in.radial_index}) * diff_r;
      d1      <= volume_height * shift_factor;
      zf1     <= (volume_height == '0) || (shift_factor == '0);
    end
  end

  // stage 2: numerator
  logic signed [40:0] n2;
  logic [DVS_W-1:0]   d2;
  logic               zf2;

  always_ff @(posedge clk) begin
    if (en) begin
      n2  <= $signed({4'b0, mh1, 8'b0}) + $signed({{3{pd1[37]}}, pd1});
      d2  <= d1;
      zf2 <= zf1;
    end
  end

  // stage 3: rounded dividend magnitude
  logic [40:0]      an2;
  logic [DIV_W-1:0] dividend3;
  logic [DVS_W-1:0] d3;
  logic             rneg3;
  logic             zf3;

  assign an2 = n2[40] ? 41'(-n2) : 41'(n2);

  always_ff @(posedge clk) begin
    if (en) begin
      dividend3 <= {an2[37:0], 10'b0} + DIV_W'(d2 >> 1);
      d3        <= d2;
      rneg3     <= n2[40];
      zf3       <= zf2;
    end
  end

  logic [DIV_W-1:0] q51;

  s2c_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (dividend3),
    .divisor  (d3),
    .quotient (q51)
  );

  logic [1:0] sd [1:DIV_W];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= {rneg3, zf3};
      for (int k = 2; k <= DIV_W; k++) sd[k] <= sd[k-1];
    end
  end

  // sine and cosine of both angles
  logic signed [CW-1:0] cos_lon, sin_lon, cos_col, sin_col;

  s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
    .clk     (clk),
    .en      (en),
    .z_in    ($signed({ang_lon.ang[15], ang_lon.ang, 12'b0})),
    .cos_out (cos_lon),
    .sin_out (sin_lon)
  );

  s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_col (
    .clk     (clk),
    .en      (en),
    .z_in    ($signed({ang_col.ang[15], ang_col.ang, 12'b0})),
    .cos_out (cos_col),
    .sin_out (sin_col)
  );

  logic [1:0] negd [1:CORDIC_STAGES];
  trig_t      cdl  [1:DLY];
  trig_t      trig_in;

  assign trig_in.cp = negd[CORDIC_STAGES][1] ? -cos_lon : cos_lon;
  assign trig_in.sp = negd[CORDIC_STAGES][1] ? -sin_lon : sin_lon;
  assign trig_in.ct = negd[CORDIC_STAGES][0] ? -cos_col : cos_col;
  assign trig_in.st = negd[CORDIC_STAGES][0] ? -sin_col : sin_col;

  always_ff @(posedge clk) begin
    if (en) begin
      negd[1] <= {ang_lon.neg, ang_col.neg};
      for (int k = 2; k <= CORDIC_STAGES; k++) negd[k] <= negd[k-1];
      // trig results wait here for the divider
      cdl[1] <= trig_in;
      for (int k = 2; k <= DLY; k++) cdl[k] <= cdl[k-1];
    end
  end

  // stage 52: angle products
  logic signed [2*CW-1:0] pc52, ps52;
  logic signed [CW-1:0]   ct52;
  logic [DIV_W-1:0]       q52;
  logic                   rneg52, zf52;

  always_ff @(posedge clk) begin
    if (en) begin
      pc52   <= cdl[DLY].cp * cdl[DLY].st;
      ps52   <= cdl[DLY].sp * cdl[DLY].st;
      ct52   <= cdl[DLY].ct;
      q52    <= q51;
      rneg52 <= sd[DIV_W][1];
      zf52   <= sd[DIV_W][0];
    end
  end

  // stage 53: round to 30 fraction bits, ties away from zero
  logic signed [2*CW-1:0] rc, rs;
  logic signed [CW-1:0]   tx53, ty53, ct53;
  logic [DIV_W-1:0]       q53;
  logic                   rneg53, zf53;

  assign rc = pc52 + (pc52[2*CW-1] ? 68'sd536870911 : 68'sd536870912);
  assign rs = ps52 + (ps52[2*CW-1] ? 68'sd536870911 : 68'sd536870912);

  always_ff @(posedge clk) begin
    if (en) begin
      tx53   <= rc[CW+29:30];
      ty53   <= rs[CW+29:30];
      ct53   <= ct52;
      q53    <= q52;
      rneg53 <= rneg52;
      zf53   <= zf52;
    end
  end

  // stage 54: magnitudes and result signs
  logic [CW-1:0]    ax54, ay54, az54;
  logic             nx54, ny54, nz54, zf54;
  logic [DIV_W-1:0] q54;

  always_ff @(posedge clk) begin
    if (en) begin
      ax54 <= tx53[CW-1] ? CW'(-tx53) : CW'(tx53);
      ay54 <= ty53[CW-1] ? CW'(-ty53) : CW'(ty53);
      az54 <= ct53[CW-1] ? CW'(-ct53) : CW'(ct53);
      nx54 <= rneg53 ^ tx53[CW-1];
      ny54 <= rneg53 ^ ty53[CW-1];
      nz54 <= rneg53 ^ ct53[CW-1];
      zf54 <= zf53;
      q54  <= q53;
    end
  end

  // stage 55: split radius into two 24 bit halves for the products
  localparam int PW = 24 + CW;
  logic [PW-1:0] hx55, lx55, hy55, ly55, hz55, lz55;
  logic          nx55, ny55, nz55, zf55;

  always_ff @(posedge clk) begin
    if (en) begin
      hx55 <= q54[47:24] * ax54;
      lx55 <= q54[23:0]  * ax54;
      hy55 <= q54[47:24] * ay54;
      ly55 <= q54[23:0]  * ay54;
      hz55 <= q54[47:24] * az54;
      lz55 <= q54[23:0]  * az54;
      nx55 <= nx54;
      ny55 <= ny54;
      nz55 <= nz54;
      zf55 <= zf54;
    end
  end

  // stage 56: recombine and round by 2^38
  logic [PW:0]   sx, sy, sz;
  logic [44:0]   mx56, my56, mz56;
  logic          nx56, ny56, nz56, zf56;

  assign sx = {1'b0, hx55} + PW'((({1'b0, lx55} + (59'd1 << 37)) >> 24));
  assign sy = {1'b0, hy55} + PW'((({1'b0, ly55} + (59'd1 << 37)) >> 24));
  assign sz = {1'b0, hz55} + PW'((({1'b0, lz55} + (59'd1 << 37)) >> 24));

  always_ff @(posedge clk) begin
    if (en) begin
      mx56 <= sx[PW:14];
      my56 <= sy[PW:14];
      mz56 <= sz[PW:14];
      nx56 <= nx55;
      ny56 <= ny55;
      nz56 <= nz55;
      zf56 <= zf55;
    end
  end

  // stage 57: saturate into the output register
  logic [OUT_W:0]     rx, ry, rz;
  logic signed [23:0] ox, oy, oz;
  logic               ofault;
  logic               ozero;

  assign rx = sat_out(nx56, mx56);
  assign ry = sat_out(ny56, my56);
  assign rz = sat_out(nz56, mz56);

  always_ff @(posedge clk) begin
    if (en) begin
      ozero  <= zf56;
      if (zf56) begin
        ox     <= '0;
        oy     <= '0;
        oz     <= '0;
        ofault <= 1'b1;
      end else begin
        ox     <= rx[OUT_W-1:0];
        oy     <= ry[OUT_W-1:0];
        oz     <= rz[OUT_W-1:0];
        ofault <= rx[OUT_W] | ry[OUT_W] | rz[OUT_W];
      end
    end
  end

  assign pt_out.valid = vld[LAT];
  assign pt_out.out_x = ox;
  assign pt_out.out_y = oy;
  assign pt_out.out_z = oz;
  assign pt_out.fault = ofault;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (pt_in.valid && pt_in.ready) |=> vld[1])
    else $error("accepted transaction did not enter the pipeline");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (vld[LAT] && ozero) |-> (ofault && ox == '0 && oy == '0 && oz == '0))
    else $error("zero divisor result not flagged");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (vld[LAT] && !pt_out.ready) |-> !pt_in.ready)
    else $error("input taken while output stalled");

endmodule

@@ dv/tb_spherical_to_cartesian_point.sv @@
// self-checking testbench for the spherical to cartesian point converter
`timescale 1ns / 100ps

module tb_spherical_to_cartesian_point;
  import s2c_pkg::*;

  localparam int STAGES = 16;
  localparam int NO_ACCEPT_LIMIT = 4000;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    logic signed [17:0] lon;
    logic        [17:0] ri;
    logic signed [16:0] colat;
  } point_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               fault;
  } cart_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  s2c_in_if  in_ch ();
  s2c_out_if out_ch ();

  spherical_to_cartesian_point #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pt_in(in_ch), .pt_out(out_ch)
  );

  // register copies used by the predictor
  longint radius_lo = 55760;
  longint radius_hi = 101936;
  longint divisor = 64000;
  longint height = 201;

  longint atan_lut [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  point_t pending_points[$];
  cart_t  expected_carts[$];
  int errors = 0;
  int src_idle = 15;
  int snk_idle = 55;
  int no_accept = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint wrap_deg(longint a_q8);
    longint m;
    m = (a_q8 * 4096 + 188743680) % 377487360;
    if (m < 0) m += 377487360;
    return m - 188743680;
  endfunction

  function automatic void cordic_sincos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874; y = 0; z = ang; flip = 0;
    if (z > 94371840) begin
      z -= 188743680; flip = 1;
    end else if (z < -94371840) begin
      z += 188743680; flip = 1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint round_shift30(longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< 29)) >>> 30;
    return v < 0 ? -m : m;
  endfunction

  // round(r * t / 2^38), ties away from zero
  function automatic longint scale_radius(longint r, longint t);
    logic [127:0] prod;
    longint unsigned ar, at;
    longint m;
    ar = r < 0 ? -r : r;
    at = t < 0 ? -t : t;
    prod = ({64'd0, ar} * {64'd0, at} + (128'd1 << 37)) >> 38;
    m = longint'(prod[63:0]);
    return ((r < 0) != (t < 0)) ? -m : m;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v, inout bit sat);
    if (v > 8388607) begin
      sat = 1; return 24'sh7FFFFF;
    end
    if (v < -8388608) begin
      sat = 1; return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic cart_t convert_point(point_t p);
    longint d, n, r, cp, sp, ct, st, tx, ty;
    longint unsigned an, q;
    bit sat;
    cart_t res;
    sat = 0;
    d = height * divisor;
    if (d == 0) begin
      res = '{x: '0, y: '0, z: '0, fault: 1'b1};
      return res;
    end
    n = radius_lo * height * 256 + longint'(p.ri) * (radius_hi - radius_lo);
    an = n < 0 ? -n : n;
    q = (an * 1024 + longint'(d) / 2) / longint'(d);
    r = n < 0 ? -longint'(q) : longint'(q);
    cordic_sincos(wrap_deg(longint'(p.lon) + 46080), cp, sp);
    cordic_sincos(wrap_deg(longint'(p.colat)), ct, st);
    tx = round_shift30(cp * st);
    ty = round_shift30(sp * st);
    res.x = clamp24(scale_radius(r, tx), sat);
    res.y = clamp24(scale_radius(r, ty), sat);
    res.z = clamp24(scale_radius(r, ct), sat);
    res.fault = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // driver: one transaction per handshake, next point loaded when the slot frees
  always @(posedge clk) begin : drive_points
    point_t cur, nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur = '{lon: in_ch.lon_deg, ri: in_ch.radial_index, colat: in_ch.colat_deg};
        expected_carts = {expected_carts, convert_point(cur)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= src_idle) begin
          nxt = pending_points.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.lon_deg <= nxt.lon;
          in_ch.radial_index <= nxt.ri;
          in_ch.colat_deg <= nxt.colat;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    cart_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_carts.size() == 0) begin
          report_mismatch("result with no point outstanding");
        end else begin
          want = expected_carts.pop_front();
          if (out_ch.out_x !== want.x)
            report_mismatch($sformatf("out_x %0d expected %0d", out_ch.out_x, want.x));
          if (out_ch.out_y !== want.y)
            report_mismatch($sformatf("out_y %0d expected %0d", out_ch.out_y, want.y));
          if (out_ch.out_z !== want.z)
            report_mismatch($sformatf("out_z %0d expected %0d", out_ch.out_z, want.z));
          if (out_ch.fault !== want.fault)
            report_mismatch($sformatf("fault %0b expected %0b", out_ch.fault, want.fault));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      no_accept <= 0;
    end else begin
      no_accept <= no_accept + 1;
      if (no_accept >= NO_ACCEPT_LIMIT) begin
        $display("spherical_to_cartesian_point test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, longint value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_MIN_RADIUS:    radius_lo = value & 'h3FFFF;
      REG_MAX_RADIUS:    radius_hi = value & 'h3FFFF;
      REG_SHIFT_FACTOR:  divisor = value & 'hFFFF;
      REG_VOLUME_HEIGHT: height = value & 'h7FF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_radial(longint lo, longint hi, longint shf, longint vh);
    write_reg(REG_MIN_RADIUS, lo);
    write_reg(REG_MAX_RADIUS, hi);
    write_reg(REG_SHIFT_FACTOR, shf);
    write_reg(REG_VOLUME_HEIGHT, vh);
  endtask

  task automatic drain;
    while (pending_points.size() > 0 || in_ch.valid || expected_carts.size() > 0)
      @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic add_point(int lon, int ri, int colat);
    point_t p;
    p.lon = lon[17:0];
    p.ri = ri[17:0];
    p.colat = colat[16:0];
    pending_points = {pending_points, p};
  endtask

  task automatic add_random_points(int count);
    int lon, ri, colat;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(3) != 0) begin
        lon = int'($urandom_range(184319)) - 92160;
        colat = int'($urandom_range(92159)) - 46080;
        ri = $urandom_range(32'((height > 0 ? height : 1) * 256));
      end else begin
        lon = $urandom();
        colat = $urandom();
        ri = $urandom();
      end
      add_point(lon, ri, colat);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.lon_deg = '0;
    in_ch.radial_index = '0;
    in_ch.colat_deg = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // field extremes, quadrant boundaries and angles that wrap past a full turn
    add_point(-92160, 0, -46080);
    add_point(92159, 262143, 46079);
    add_point(0, 0, 0);
    add_point(-46080, 201 * 256, 23040);
    add_point(23040, 100 * 256, -23040);
    add_point(-23040, 50 * 256, 11520);
    add_point(46080, 200 * 256, -11520);
    add_point(131071, 12345, 65535);
    add_point(-131072, 262143, -65536);
    add_point(23041, 7, 23041);
    add_point(-23041, 99999, -23041);
    add_point(1, 1, 1);
    add_point(-1, 256, -1);
    add_point(69120, 128, 34560);
    add_point(-69120, 25600, -34560);
    add_point(0, 262143, 23040);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 2 && ph < 5) begin
        src_idle = 55; snk_idle = 15;
      end else if (ph >= 5) begin
        src_idle = 0; snk_idle = 0;
      end
      case (ph)
        0: set_radial(0, 160000, 64000, 1024);
        1: set_radial(160000, 0, 64000, 201);
        2: set_radial(100000, 100000, 0, 201);
        3: set_radial(55760, 101936, 1, 1);
        4: set_radial(262143, 262143, 65535, 2047);
        5: set_radial(0, 0, 64, 0);
        6: set_radial($urandom(), $urandom(), $urandom_range(65535), $urandom_range(2047, 1));
        default: set_radial(55760, 101936, 64000, 201);
      endcase
      add_random_points(PHASE_ITEMS);
      drain();
    end

    if (errors == 0)
      $display("spherical_to_cartesian_point test passed");
    else
      $display("spherical_to_cartesian_point test failed");
    $finish;
  end

endmodule
